/* sv/ille_pkg.sv */
// ----------------------------------------------------------------------------
// ille_pkg
// Shared codes and controller/datapath interface types for the linked list
// engine.
// ----------------------------------------------------------------------------
package ille_pkg;

    localparam logic [2:0] MODE_READ     = 3'd0;
    localparam logic [2:0] MODE_INS_HEAD = 3'd1;
    localparam logic [2:0] MODE_INS_TAIL = 3'd2;
    localparam logic [2:0] MODE_INS_AT   = 3'd3;
    localparam logic [2:0] MODE_DELETE   = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam int POS_W   = 9;
    localparam int VALUE_W = 32;

    // controller -> datapath
    typedef struct packed {
        logic       load_req;
        logic       walk_start;
        logic       walk_minus1;
        logic       walk_step;
        logic       val_rd;
        logic       pop_rd;
        logic       pop_take;
        logic       head_wr;
        logic       tail_wr0;
        logic       tail_wr1;
        logic       mid_wr0;
        logic       mid_wr1;
        logic       delh_rd;
        logic       delh_wr;
        logic       del_rd;
        logic       del_wr;
        logic       set_status;
        logic [1:0] status_code;
        logic       out_load;
    } ille_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] mode;
        logic       pos_zero;
        logic       pos_ge_cnt;
        logic       pos_gt_cnt;
        logic       cnt_zero;
        logic       store_full;
        logic       walk_done;
        logic       out_busy;
    } ille_stat_t;

endpackage

/* sv/indexed_linked_list_engine_core.sv */
// ----------------------------------------------------------------------------
// indexed_linked_list_engine_core
// Singly linked list in slot memories with a free-slot stack; read, insert
// and delete by list index.
// ----------------------------------------------------------------------------
//  channel  | signals                              | transfer when
//  ---------+--------------------------------------+-----------------------
//  request  | mode, position, item_value           | in_valid & in_ready
//  result   | read_value, status, list_count       | out_valid & out_ready
//
//  One request at a time. A failed check or an unused mode goes from decode
//  straight to the result; head and tail inserts pop a free slot and write
//  the links; reads, deletes and inserts before an index walk the list to
//  the position first, and the walk over the link memory takes one cycle
//  per link.
//  Reset is asynchronous; no clearing pass: the free stack's reset contents
//  are served from a low-water mark until overwritten.
//  A finished result waits in the output register; the next request is taken
//  meanwhile and holds in its result state until the output register frees.
// ----------------------------------------------------------------------------
module indexed_linked_list_engine_core #(
    parameter int CAPACITY = 256
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [2:0]                           mode,
    input  logic [ille_pkg::POS_W-1:0]           position,
    input  logic signed [ille_pkg::VALUE_W-1:0]  item_value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [ille_pkg::VALUE_W-1:0]  read_value,
    output logic [1:0]                           status,
    output logic [ille_pkg::POS_W-1:0]           list_count
);

    ille_pkg::ille_cmd_t  cmd;
    ille_pkg::ille_stat_t stat;

    // sequencer
    ille_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // memories, pointers and result register
    ille_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode       (mode),
        .position   (position),
        .item_value (item_value),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_value (read_value),
        .status     (status),
        .list_count (list_count)
    );

endmodule

/* sv/ille_datapath.sv */
// ----------------------------------------------------------------------------
// ille_datapath
// Slot memories, free-slot stack, list pointers and the result register.
// ----------------------------------------------------------------------------
module ille_datapath #(
    parameter int CAPACITY = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [2:0]                    mode,
    input  logic [ille_pkg::POS_W-1:0]    position,
    input  logic signed [ille_pkg::VALUE_W-1:0] item_value,
    input  ille_pkg::ille_cmd_t           cmd,
    output ille_pkg::ille_stat_t          stat,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [ille_pkg::VALUE_W-1:0] read_value,
    output logic [1:0]                    status,
    output logic [ille_pkg::POS_W-1:0]    list_count
);

    localparam int IW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CW > ille_pkg::POS_W) ? CW : ille_pkg::POS_W;

    logic [ille_pkg::VALUE_W-1:0] val_mem [CAPACITY];
    logic [IW-1:0]                link_mem [CAPACITY];
    logic [IW-1:0]                stk_mem [CAPACITY];

    logic [2:0]                   mode_reg;
    logic [ille_pkg::POS_W-1:0]   pos_reg;
    logic [ille_pkg::VALUE_W-1:0] item_reg;
    logic [ille_pkg::VALUE_W-1:0] val_q;
    logic [IW-1:0]                link_q;
    logic [IW-1:0]                stk_q;

    logic [IW-1:0]                head_reg;
    logic [IW-1:0]                tail_reg;
    logic [IW-1:0]                cur_reg;
    logic [IW-1:0]                slot_reg;
    logic [IW-1:0]                dslot_reg;
    logic [CW-1:0]                cnt_reg;
    logic [CW-1:0]                fc_reg;
    logic [CW-1:0]                min_reg;
    logic [ille_pkg::POS_W-1:0]   left_reg;
    logic [1:0]                   st_reg;
    logic                         out_valid_reg;
    logic [ille_pkg::VALUE_W-1:0] rv_reg;
    logic [1:0]                   status_reg;
    logic [ille_pkg::POS_W-1:0]   count_reg;

    logic [CMP_W-1:0]             pos_ext;
    logic [CMP_W-1:0]             cnt_ext;
    logic [CW-1:0]                fc_dec;
    logic                         pop_low;
    logic                         link_we;
    logic [IW-1:0]                link_waddr;
    logic [IW-1:0]                link_wdata;
    logic                         link_re;
    logic [IW-1:0]                link_raddr;
    logic                         push;
    logic                         val_we;
    logic [ille_pkg::VALUE_W-1:0] rv_next;

    assign pos_ext = CMP_W'(pos_reg);
    assign cnt_ext = CMP_W'(cnt_reg);
    assign fc_dec  = fc_reg - 1'b1;
    // stack entries below the low-water mark still hold their reset slot number
    assign pop_low = (fc_dec < min_reg);
    assign push    = cmd.del_wr | cmd.delh_wr;
    assign val_we  = cmd.head_wr | cmd.tail_wr0 | cmd.mid_wr0;

    always_comb
    begin
        link_we    = 1'b1;
        link_waddr = slot_reg;
        link_wdata = head_reg;
        if (cmd.head_wr)
        begin
            link_waddr = slot_reg;
            link_wdata = head_reg;
        end
        else if (cmd.tail_wr0)
        begin
            link_waddr = slot_reg;
            link_wdata = '0;
        end
        else if (cmd.tail_wr1)
        begin
            link_waddr = tail_reg;
            link_wdata = slot_reg;
        end
        else if (cmd.mid_wr0)
        begin
            link_waddr = slot_reg;
            link_wdata = link_q;
        end
        else if (cmd.mid_wr1)
        begin
            link_waddr = cur_reg;
            link_wdata = slot_reg;
        end
        else if (cmd.del_wr)
        begin
            link_waddr = cur_reg;
            link_wdata = link_q;
        end
        else
        begin
            link_we = 1'b0;
        end
    end

    always_comb
    begin
        link_re    = 1'b1;
        link_raddr = head_reg;
        if (cmd.walk_start | cmd.delh_rd)
        begin
            link_raddr = head_reg;
        end
        else if (cmd.walk_step | cmd.del_rd)
        begin
            link_raddr = link_q;
        end
        else
        begin
            link_re = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[slot_reg] <= item_reg;
        end
        if (cmd.val_rd)
        begin
            val_q <= val_mem[cur_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (link_re)
        begin
            link_q <= link_mem[link_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            stk_mem[fc_reg[IW-1:0]] <= dslot_reg;
        end
        if (cmd.pop_rd)
        begin
            stk_q <= stk_mem[fc_dec[IW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            mode_reg <= mode;
            pos_reg  <= position;
            item_reg <= item_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            cur_reg   <= '0;
            slot_reg  <= '0;
            dslot_reg <= '0;
            cnt_reg   <= '0;
            fc_reg    <= CW'(CAPACITY);
            min_reg   <= CW'(CAPACITY);
            left_reg  <= '0;
            st_reg    <= ille_pkg::ST_OK;
        end
        else
        begin
            if (cmd.load_req)
            begin
                st_reg <= ille_pkg::ST_OK;
            end
            if (cmd.set_status)
            begin
                st_reg <= cmd.status_code;
            end
            if (cmd.walk_start)
            begin
                cur_reg  <= head_reg;
                left_reg <= cmd.walk_minus1 ? (pos_reg - 1'b1) : pos_reg;
            end
            if (cmd.walk_step)
            begin
                cur_reg  <= link_q;
                left_reg <= left_reg - 1'b1;
            end
            if (cmd.pop_take)
            begin
                slot_reg <= pop_low ? fc_dec[IW-1:0] : stk_q;
                fc_reg   <= fc_dec;
                if (pop_low)
                begin
                    min_reg <= fc_dec;
                end
            end
            if (cmd.head_wr)
            begin
                head_reg <= slot_reg;
                if (cnt_reg == '0)
                begin
                    tail_reg <= slot_reg;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.tail_wr1)
            begin
                tail_reg <= slot_reg;
                cnt_reg  <= cnt_reg + 1'b1;
            end
            if (cmd.mid_wr1)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.delh_rd)
            begin
                dslot_reg <= head_reg;
            end
            if (cmd.del_rd)
            begin
                dslot_reg <= link_q;
            end
            if (cmd.delh_wr)
            begin
                fc_reg  <= fc_reg + 1'b1;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    head_reg <= '0;
                    tail_reg <= '0;
                end
                else
                begin
                    head_reg <= link_q;
                end
            end
            if (cmd.del_wr)
            begin
                fc_reg  <= fc_reg + 1'b1;
                cnt_reg <= cnt_reg - 1'b1;
                // deleting the last entry: predecessor becomes the tail
                if (pos_ext == cnt_ext - 1'b1)
                begin
                    tail_reg <= cur_reg;
                end
            end
        end
    end

    always_comb
    begin
        if (st_reg != ille_pkg::ST_OK)
        begin
            rv_next = '1;
        end
        else if (mode_reg == ille_pkg::MODE_READ)
        begin
            rv_next = val_q;
        end
        else
        begin
            rv_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            rv_reg     <= rv_next;
            status_reg <= st_reg;
            count_reg  <= cnt_ext[ille_pkg::POS_W-1:0];
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = rv_reg;
    assign status     = status_reg;
    assign list_count = count_reg;

    assign stat.mode       = mode_reg;
    assign stat.pos_zero   = (pos_reg == '0);
    assign stat.pos_ge_cnt = (pos_ext >= cnt_ext);
    assign stat.pos_gt_cnt = (pos_ext > cnt_ext);
    assign stat.cnt_zero   = (cnt_reg == '0);
    assign stat.store_full = (fc_reg == '0);
    assign stat.walk_done  = (left_reg == '0);
    assign stat.out_busy   = out_valid_reg & ~out_ready;

`ifndef SYNTHESIS
    // a popped slot is off the stack before it is linked, so the sum dips by one
    a_slot_balance: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, fc_reg} + {1'b0, cnt_reg}) <= (CW + 1)'(CAPACITY))
        else $error("free count plus entry count exceeds capacity");

    a_low_mark: assert property (@(posedge clk) disable iff (!rst_n)
        min_reg <= fc_reg)
        else $error("stack low-water mark above free count");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (head_reg == '0 && tail_reg == '0))
        else $error("empty list with stale head or tail");
`endif

endmodule

/* sv/ille_ctrl.sv */
// ----------------------------------------------------------------------------
// ille_ctrl
// Sequencer: decodes a request and steps the datapath through pop, walk,
// link update and result load.
// ----------------------------------------------------------------------------
module ille_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ille_pkg::ille_stat_t stat,
    output ille_pkg::ille_cmd_t  cmd
);

    typedef enum logic [16:0] {
        S_IDLE     = 17'd1,
        S_DECODE   = 17'd2,
        S_POP_RD   = 17'd4,
        S_POP_TAKE = 17'd8,
        S_WALK     = 17'd16,
        S_VAL_RD   = 17'd32,
        S_HEAD_WR  = 17'd64,
        S_TAIL_WR0 = 17'd128,
        S_TAIL_WR1 = 17'd256,
        S_MID_WR0  = 17'd512,
        S_MID_WR1  = 17'd1024,
        S_DELH_RD  = 17'd2048,
        S_DELH_WR  = 17'd4096,
        S_DEL_RD   = 17'd8192,
        S_DEL_WR   = 17'd16384,
        S_RESP     = 17'd32768,
        S_SPARE    = 17'd65536
    } state_t;

    typedef enum logic [2:0] {
        OP_READ,
        OP_HEAD,
        OP_TAIL,
        OP_MID,
        OP_DEL
    } op_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_READ;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_RESP;
                case (stat.mode)
                    ille_pkg::MODE_READ:
                    begin
                        if (stat.pos_ge_cnt)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ille_pkg::ST_RANGE;
                        end
                        else
                        begin
                            op_next        = OP_READ;
                            cmd.walk_start = 1'b1;
                            state_next     = S_WALK;
                        end
                    end
                    ille_pkg::MODE_INS_HEAD, ille_pkg::MODE_INS_TAIL:
                    begin
                        if (stat.store_full)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ille_pkg::ST_FULL;
                        end
                        else
                        begin
                            op_next = (stat.mode == ille_pkg::MODE_INS_HEAD || stat.cnt_zero)
                                      ? OP_HEAD : OP_TAIL;
                            state_next = S_POP_RD;
                        end
                    end
                    ille_pkg::MODE_INS_AT:
                    begin
                        if (stat.pos_gt_cnt)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ille_pkg::ST_RANGE;
                        end
                        else if (stat.store_full)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ille_pkg::ST_FULL;
                        end
                        else
                        begin
                            if (stat.pos_zero)
                                op_next = OP_HEAD;
                            else if (stat.pos_ge_cnt)
                                op_next = OP_TAIL;
                            else
                                op_next = OP_MID;
                            state_next = S_POP_RD;
                        end
                    end
                    ille_pkg::MODE_DELETE:
                    begin
                        if (stat.pos_ge_cnt)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ille_pkg::ST_RANGE;
                        end
                        else if (stat.pos_zero)
                        begin
                            state_next = S_DELH_RD;
                        end
                        else
                        begin
                            op_next         = OP_DEL;
                            cmd.walk_start  = 1'b1;
                            cmd.walk_minus1 = 1'b1;
                            state_next      = S_WALK;
                        end
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_POP_RD:
            begin
                cmd.pop_rd = 1'b1;
                state_next = S_POP_TAKE;
            end
            S_POP_TAKE:
            begin
                cmd.pop_take = 1'b1;
                case (op_reg)
                    OP_HEAD: state_next = S_HEAD_WR;
                    OP_TAIL: state_next = S_TAIL_WR0;
                    default:
                    begin
                        cmd.walk_start  = 1'b1;
                        cmd.walk_minus1 = 1'b1;
                        state_next      = S_WALK;
                    end
                endcase
            end
            S_WALK:
            begin
                if (stat.walk_done)
                begin
                    case (op_reg)
                        OP_READ: state_next = S_VAL_RD;
                        OP_MID:  state_next = S_MID_WR0;
                        default: state_next = S_DEL_RD;
                    endcase
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                end
            end
            S_VAL_RD:
            begin
                cmd.val_rd = 1'b1;
                state_next = S_RESP;
            end
            S_HEAD_WR:
            begin
                cmd.head_wr = 1'b1;
                state_next  = S_RESP;
            end
            S_TAIL_WR0:
            begin
                cmd.tail_wr0 = 1'b1;
                state_next   = S_TAIL_WR1;
            end
            S_TAIL_WR1:
            begin
                cmd.tail_wr1 = 1'b1;
                state_next   = S_RESP;
            end
            S_MID_WR0:
            begin
                cmd.mid_wr0 = 1'b1;
                state_next  = S_MID_WR1;
            end
            S_MID_WR1:
            begin
                cmd.mid_wr1 = 1'b1;
                state_next  = S_RESP;
            end
            S_DELH_RD:
            begin
                cmd.delh_rd = 1'b1;
                state_next  = S_DELH_WR;
            end
            S_DELH_WR:
            begin
                cmd.delh_wr = 1'b1;
                state_next  = S_RESP;
            end
            S_DEL_RD:
            begin
                cmd.del_rd = 1'b1;
                state_next = S_DEL_WR;
            end
            S_DEL_WR:
            begin
                cmd.del_wr = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("request taken while sequencer busy");

    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_req |=> (state_reg == S_DECODE))
        else $error("request load did not reach decode");

    a_result_single: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> (state_reg == S_IDLE))
        else $error("result load not followed by idle");
`endif

endmodule
